FILE: rtl/first_fit_free_list_allocator_macros.svh
// assertion macros for the free-list allocator
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define FFA_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define FFA_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/ffa_pkg.sv
// types, constants and helpers shared by the allocator modules
`timescale 1ns / 1ps
`default_nettype none
package ffa_pkg;

  localparam int MAX_EXTENTS  = 64;
  localparam int HEADER_BYTES = 8;
  localparam int IDX_W        = $clog2(MAX_EXTENTS);
  localparam int CNT_W        = IDX_W + 1;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = QPTR_W + 1;
  localparam int CFG_IDX_W    = 2;

  localparam logic [15:0] RST_RESERVED = 16'd4096;
  localparam logic [31:0] RST_REGION   = 32'd65536;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFIT  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_BADOFF = 2'd3;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION   = 2'd1;

  typedef struct packed {
    logic        func;
    logic [31:0] req_bytes;
    logic [31:0] payload_offset_in;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] payload_offset;
  } out_t;

  typedef struct packed {
    logic [15:0] reserved;
    logic [31:0] region_end;
  } cfg_t;

  // classified item as it waits in the queue
  typedef struct packed {
    logic        func;
    logic [1:0]  pre_status;
    logic [32:0] need;
    logic [31:0] blk_start;
    logic [33:0] blk_end;
  } op_t;

  typedef struct packed {
    logic             idle;
    logic [CNT_W-1:0] count;
  } bk_status_t;

  // lowest set bit, MAX_EXTENTS when none
  function automatic logic [CNT_W-1:0] first_set(input logic [MAX_EXTENTS-1:0] v);
    logic [CNT_W-1:0] r;
    r = CNT_W'(MAX_EXTENTS);
    for (int i = MAX_EXTENTS - 1; i >= 0; i--) begin
      if (v[i]) r = CNT_W'(i);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/first_fit_free_list_allocator.sv
// top level of the first-fit free-list allocator
//
//  channel  ports                                   handshake
//  in       start, busy, in_item                    taken when start and not busy
//  out      out_valid, out_item                     one-cycle strobe, never held off
//  cfg      cfg_valid, cfg_ready, cfg_index, cfg_data  written when valid and ready
//
// an item failing the size or range check goes from the queue straight to the output register
// an item with no fit or an overlap gives its result from the select state, with no update
// any other item passes queue, compare, select, update and output in that order
// the back end takes a new item only once it is back in its idle state
// reset leaves one extent from 4096 to 65536; a write to either register rebuilds the list
// in the cycle after; cfg_ready only while queue and back end are empty and no rebuild
// is pending; busy rises while the two-entry queue is full or a register is being
// written; results cannot be stalled
`timescale 1ns / 1ps
`default_nettype none
`include "first_fit_free_list_allocator_macros.svh"
module first_fit_free_list_allocator (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             start,
  output logic                            busy,
  input  ffa_pkg::in_t                    in_item,
  output logic                            out_valid,
  output ffa_pkg::out_t                   out_item,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire [ffa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [31:0]                      cfg_data
);
  import ffa_pkg::*;

  // configuration registers
  logic [15:0] reserved_r;
  logic [31:0] region_r;
  logic        init_r, init_nxt;
  logic        cfg_wr;
  cfg_t        cfg;

  // front to back queue
  op_t        front_op, q_data;
  logic       q_push, q_pop, q_empty, q_full;
  bk_status_t bk_status;

  // writes only with nothing in flight and no rebuild pending
  assign cfg_ready = q_empty && bk_status.idle && !init_r;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign init_nxt  = cfg_wr && (cfg_index == CFG_RESERVED || cfg_index == CFG_REGION);

  // region end is the region size; 32-bit offsets never need clamping
  assign cfg.reserved   = reserved_r;
  assign cfg.region_end = region_r;

  // no item is taken at the edge of a register write
  assign busy   = q_full || cfg_wr;
  assign q_push = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reserved_r <= RST_RESERVED;
      region_r   <= RST_REGION;
      init_r     <= 1'b0;
    end else begin
      init_r <= init_nxt;
      if (cfg_wr && cfg_index == CFG_RESERVED) reserved_r <= cfg_data[15:0];
      if (cfg_wr && cfg_index == CFG_REGION)   region_r   <= cfg_data;
    end
  end

  // classify on the way in
  ffa_front u_front (
    .in_item (in_item),
    .cfg     (cfg),
    .op      (front_op)
  );

  ffa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (front_op),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty),
    .full      (q_full)
  );

  // extent list and its search and update
  ffa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .init      (init_r),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_item  (out_item),
    .status    (bk_status)
  );

  `FFA_CHECK(a_count_bound, 1'b1, bk_status.count <= CNT_W'(MAX_EXTENTS), "extent count overflow")
  `FFA_CHECK(a_fail_zero, out_valid && out_item.status != ST_OK, out_item.payload_offset == 32'd0, "failed item with non-zero offset")
  `FFA_CHECK(a_full_count, out_valid && out_item.status == ST_FULL, bk_status.count == CNT_W'(MAX_EXTENTS), "list full reported below capacity")
  `FFA_CHECK_NEXT(a_busy_full, q_full && !q_pop, busy, "queue full but item accepted")

endmodule
`default_nettype wire

FILE: rtl/ffa_front.sv
// front end: size and range checks on an incoming item
`timescale 1ns / 1ps
`default_nettype none
module ffa_front (
  input  ffa_pkg::in_t  in_item,
  input  ffa_pkg::cfg_t cfg,
  output ffa_pkg::op_t  op
);
  import ffa_pkg::*;

  logic        zero_size;
  logic        bad_off;
  logic [32:0] need;
  logic [31:0] blk_start;
  logic [33:0] blk_end;

  assign zero_size = (in_item.req_bytes == 32'd0);
  assign need      = {1'b0, in_item.req_bytes} + 33'(HEADER_BYTES);
  assign blk_start = in_item.payload_offset_in - 32'(HEADER_BYTES);
  assign blk_end   = {2'b00, blk_start} + {1'b0, need};
  assign bad_off   = (in_item.payload_offset_in < 32'(HEADER_BYTES))
                   || (blk_start < {16'd0, cfg.reserved})
                   || (blk_end > {2'b00, cfg.region_end});

  always_comb begin
    op.func      = in_item.func;
    op.need      = need;
    op.blk_start = blk_start;
    op.blk_end   = blk_end;
    if (zero_size) op.pre_status = ST_NOFIT;
    else if (in_item.func == FUNC_FREE && bad_off) op.pre_status = ST_BADOFF;
    else op.pre_status = ST_OK;
  end

endmodule
`default_nettype wire

FILE: rtl/ffa_queue.sv
// short queue of classified items between front and back
`timescale 1ns / 1ps
`default_nettype none
module ffa_queue (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           push,
  input  ffa_pkg::op_t  push_data,
  input  wire           pop,
  output ffa_pkg::op_t  pop_data,
  output logic          empty,
  output logic          full
);
  import ffa_pkg::*;

  op_t               mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign empty    = (cnt_r == QCNT_W'(0));
  assign full     = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule
`default_nettype wire

FILE: rtl/ffa_back.sv
// back end: extent cell chain with search, carve, merge and shift
`timescale 1ns / 1ps
`default_nettype none
module ffa_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  ffa_pkg::cfg_t       cfg,
  input  wire                 init,
  input  wire                 q_empty,
  input  ffa_pkg::op_t        q_data,
  output logic                q_pop,
  output logic                out_valid,
  output ffa_pkg::out_t       out_item,
  output ffa_pkg::bk_status_t status
);
  import ffa_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_SEL  = 2'd2;
  localparam logic [1:0] S_UPD  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  op_t              op_r, op_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_r, out_nxt;

  logic [31:0] base_r [MAX_EXTENTS];
  logic [31:0] len_r  [MAX_EXTENTS];
  logic [31:0] base_nxt [MAX_EXTENTS];
  logic [31:0] len_nxt  [MAX_EXTENTS];

  logic [MAX_EXTENTS-1:0] fit_c, ovl_c, lt_c;
  logic [MAX_EXTENTS-1:0] fit_r, ovl_r, lt_r;

  logic [CNT_W-1:0] sel_idx_r, sel_idx_nxt;
  logic [31:0]      cur_base_r, cur_base_nxt, cur_len_r, cur_len_nxt;
  logic [31:0]      prev_base_r, prev_base_nxt, prev_len_r, prev_len_nxt;

  logic [CNT_W-1:0] fit_idx, ins_idx, sel_idx_c;
  logic [IDX_W-1:0] prev_idx;
  logic [31:0]      new_len;
  logic [32:0]      prev_end;
  logic             prev_adj, next_adj;
  logic [32:0]      init_end_ext;
  logic [31:0]      init_len;
  logic             init_nonempty;

  logic             do_wr, do_shl, do_shr;
  logic [IDX_W-1:0] wr_at;
  logic [CNT_W-1:0] shl_at, shr_at;
  logic [31:0]      wr_base, wr_len;

  assign out_valid    = out_valid_r;
  assign out_item     = out_r;
  assign status.idle  = (state_r == S_IDLE);
  assign status.count = count_r;

  assign init_end_ext  = {1'b0, cfg.region_end};
  assign init_nonempty = init_end_ext > {17'd0, cfg.reserved};
  assign init_len      = cfg.region_end - {16'd0, cfg.reserved};

  // per-cell compares against the item in hand
  always_comb begin
    for (int i = 0; i < MAX_EXTENTS; i++) begin
      fit_c[i] = (CNT_W'(i) < count_r) && ({1'b0, len_r[i]} >= op_r.need);
      ovl_c[i] = (CNT_W'(i) < count_r)
               && ({1'b0, op_r.blk_start} < ({1'b0, base_r[i]} + {1'b0, len_r[i]}))
               && ({2'b00, base_r[i]} < op_r.blk_end);
      lt_c[i]  = (CNT_W'(i) < count_r) && (base_r[i] < op_r.blk_start);
    end
  end

  assign fit_idx   = first_set(fit_r);
  assign ins_idx   = first_set(~lt_r);
  assign sel_idx_c = (op_r.func == FUNC_ALLOC) ? fit_idx : ins_idx;
  assign prev_idx  = IDX_W'(ins_idx - 1'b1);

  assign new_len  = cur_len_r - op_r.need[31:0];
  assign prev_end = {1'b0, prev_base_r} + {1'b0, prev_len_r};
  assign prev_adj = (sel_idx_r != '0) && (prev_end == {1'b0, op_r.blk_start});
  assign next_adj = (sel_idx_r < count_r) && ({2'b00, cur_base_r} == op_r.blk_end);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    sel_idx_nxt   = sel_idx_r;
    cur_base_nxt  = cur_base_r;
    cur_len_nxt   = cur_len_r;
    prev_base_nxt = prev_base_r;
    prev_len_nxt  = prev_len_r;
    do_wr   = 1'b0;
    do_shl  = 1'b0;
    do_shr  = 1'b0;
    wr_at   = sel_idx_r[IDX_W-1:0];
    shl_at  = sel_idx_r;
    shr_at  = sel_idx_r;
    wr_base = cur_base_r;
    wr_len  = cur_len_r;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop  = 1'b1;
          op_nxt = q_data;
          if (q_data.pre_status != ST_OK) begin
            out_valid_nxt          = 1'b1;
            out_nxt.status         = q_data.pre_status;
            out_nxt.payload_offset = 32'd0;
          end else begin
            state_nxt = S_CMP;
          end
        end
      end
      S_CMP: state_nxt = S_SEL;
      S_SEL: begin
        sel_idx_nxt   = sel_idx_c;
        cur_base_nxt  = base_r[sel_idx_c[IDX_W-1:0]];
        cur_len_nxt   = len_r[sel_idx_c[IDX_W-1:0]];
        prev_base_nxt = base_r[prev_idx];
        prev_len_nxt  = len_r[prev_idx];
        if (op_r.func == FUNC_ALLOC && fit_idx == CNT_W'(MAX_EXTENTS)) begin
          out_valid_nxt          = 1'b1;
          out_nxt.status         = ST_NOFIT;
          out_nxt.payload_offset = 32'd0;
          state_nxt              = S_IDLE;
        end else if (op_r.func == FUNC_FREE && (|ovl_r)) begin
          out_valid_nxt          = 1'b1;
          out_nxt.status         = ST_BADOFF;
          out_nxt.payload_offset = 32'd0;
          state_nxt              = S_IDLE;
        end else begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        state_nxt              = S_IDLE;
        out_valid_nxt          = 1'b1;
        out_nxt.status         = ST_OK;
        out_nxt.payload_offset = 32'd0;
        if (op_r.func == FUNC_ALLOC) begin
          out_nxt.payload_offset = cur_base_r + 32'(HEADER_BYTES);
          if (new_len == 32'd0) begin
            do_shl    = 1'b1;
            count_nxt = count_r - 1'b1;
          end else begin
            do_wr   = 1'b1;
            wr_base = cur_base_r + op_r.need[31:0];
            wr_len  = new_len;
          end
        end else if (prev_adj && next_adj) begin
          do_wr     = 1'b1;
          wr_at     = IDX_W'(sel_idx_r - 1'b1);
          wr_base   = prev_base_r;
          wr_len    = prev_len_r + op_r.need[31:0] + cur_len_r;
          do_shl    = 1'b1;
          count_nxt = count_r - 1'b1;
        end else if (next_adj) begin
          do_wr   = 1'b1;
          wr_base = op_r.blk_start;
          wr_len  = cur_len_r + op_r.need[31:0];
        end else if (prev_adj) begin
          do_wr   = 1'b1;
          wr_at   = IDX_W'(sel_idx_r - 1'b1);
          wr_base = prev_base_r;
          wr_len  = prev_len_r + op_r.need[31:0];
        end else if (count_r >= CNT_W'(MAX_EXTENTS)) begin
          out_nxt.status = ST_FULL;
        end else begin
          do_wr     = 1'b1;
          do_shr    = 1'b1;
          wr_base   = op_r.blk_start;
          wr_len    = op_r.need[31:0];
          count_nxt = count_r + 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (init) count_nxt = {{(CNT_W-1){1'b0}}, init_nonempty};
  end

  // each cell takes its own value, a neighbour's, or the new extent
  always_comb begin
    for (int i = 0; i < MAX_EXTENTS; i++) begin
      base_nxt[i] = base_r[i];
      len_nxt[i]  = len_r[i];
      if (do_wr && wr_at == IDX_W'(i)) begin
        base_nxt[i] = wr_base;
        len_nxt[i]  = wr_len;
      end else if (do_shl && CNT_W'(i) >= shl_at && i < MAX_EXTENTS - 1) begin
        base_nxt[i] = base_r[(i + 1) % MAX_EXTENTS];
        len_nxt[i]  = len_r[(i + 1) % MAX_EXTENTS];
      end else if (do_shr && CNT_W'(i) > shr_at && i > 0) begin
        base_nxt[i] = base_r[(i + MAX_EXTENTS - 1) % MAX_EXTENTS];
        len_nxt[i]  = len_r[(i + MAX_EXTENTS - 1) % MAX_EXTENTS];
      end
    end
    if (init) begin
      base_nxt[0] = {16'd0, cfg.reserved};
      len_nxt[0]  = init_len;
    end
    // reset extent covers the default region after the reserve
    if (!rst_n) begin
      base_nxt[0] = {16'd0, RST_RESERVED};
      len_nxt[0]  = RST_REGION - {16'd0, RST_RESERVED};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    out_r       <= out_nxt;
    fit_r       <= fit_c;
    ovl_r       <= ovl_c;
    lt_r        <= lt_c;
    sel_idx_r   <= sel_idx_nxt;
    cur_base_r  <= cur_base_nxt;
    cur_len_r   <= cur_len_nxt;
    prev_base_r <= prev_base_nxt;
    prev_len_r  <= prev_len_nxt;
    for (int i = 0; i < MAX_EXTENTS; i++) begin
      base_r[i] <= base_nxt[i];
      len_r[i]  <= len_nxt[i];
    end
  end

endmodule
`default_nettype wire

FILE: tb/sv/first_fit_free_list_allocator_tb.sv
// testbench for the first-fit free-list allocator: directed and random items against a predictor
`timescale 1ns / 1ps
`default_nettype none
module first_fit_free_list_allocator_tb;
  import ffa_pkg::*;

  // write to a register index that does not exist
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 12;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t in_item;
  logic out_valid;
  out_t out_item;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  first_fit_free_list_allocator uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock, 12 ns period
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // predictor copy of the free list and registers
  logic [63:0] pr_reserved;
  logic [63:0] pr_region;
  logic [31:0] ext_base [MAX_EXTENTS];
  logic [31:0] ext_len [MAX_EXTENTS];
  int ext_count;

  // results still owed by the block, oldest first
  out_t owed_results[$];
  // blocks currently handed out: payload offset and requested size
  logic [31:0] live_off[$];
  logic [31:0] live_req[$];

  int errors = 0;
  bit no_gaps = 0;

  function automatic logic [63:0] region_limit();
    return (pr_region < 64'hFFFF_FFFF) ? pr_region : 64'hFFFF_FFFF;
  endfunction

  function automatic void rebuild_list();
    logic [63:0] lim;
    lim = region_limit();
    if (lim > pr_reserved) begin
      ext_base[0] = pr_reserved[31:0];
      ext_len[0] = 32'(lim - pr_reserved);
      ext_count = 1;
    end else begin
      ext_count = 0;
    end
  endfunction

  function automatic void drop_extent(int p);
    for (int j = p; j + 1 < ext_count; j++) begin
      ext_base[j] = ext_base[j + 1];
      ext_len[j] = ext_len[j + 1];
    end
    ext_count--;
  endfunction

  // first fit: carve request plus header from the front of the first big enough extent
  function automatic out_t predict_alloc(logic [31:0] req);
    out_t r;
    logic [63:0] need;
    r.status = ST_NOFIT;
    r.payload_offset = '0;
    need = 64'(req) + HEADER_BYTES;
    if (req == 0) return r;
    for (int i = 0; i < ext_count; i++) begin
      if (64'(ext_len[i]) >= need) begin
        r.status = ST_OK;
        r.payload_offset = ext_base[i] + HEADER_BYTES;
        ext_base[i] = 32'(64'(ext_base[i]) + need);
        ext_len[i] = 32'(64'(ext_len[i]) - need);
        if (ext_len[i] == 0) drop_extent(i);
        return r;
      end
    end
    return r;
  endfunction

  // give a block back, merging with neighbours where they touch
  function automatic logic [1:0] predict_free(logic [31:0] req, logic [31:0] off);
    logic [63:0] b_start, b_size, b_end, eb, ee;
    int p;
    bit prev_adj, next_adj;
    p = 0;
    if (req == 0) return ST_NOFIT;
    if (off < HEADER_BYTES) return ST_BADOFF;
    b_start = 64'(off) - HEADER_BYTES;
    b_size = 64'(req) + HEADER_BYTES;
    b_end = b_start + b_size;
    if (b_start < pr_reserved || b_end > region_limit()) return ST_BADOFF;
    for (int i = 0; i < ext_count; i++) begin
      eb = 64'(ext_base[i]);
      ee = eb + 64'(ext_len[i]);
      if (b_start < ee && eb < b_end) return ST_BADOFF;
      if (eb < b_start) p = i + 1;
    end
    prev_adj = p > 0 && (64'(ext_base[p-1]) + 64'(ext_len[p-1]) == b_start);
    next_adj = p < ext_count && (64'(ext_base[p]) == b_end);
    if (prev_adj && next_adj) begin
      ext_len[p-1] = 32'(64'(ext_len[p-1]) + b_size + 64'(ext_len[p]));
      drop_extent(p);
    end else if (next_adj) begin
      ext_base[p] = b_start[31:0];
      ext_len[p] = 32'(64'(ext_len[p]) + b_size);
    end else if (prev_adj) begin
      ext_len[p-1] = 32'(64'(ext_len[p-1]) + b_size);
    end else begin
      if (ext_count >= MAX_EXTENTS) return ST_FULL;
      for (int i = ext_count; i > p; i--) begin
        ext_base[i] = ext_base[i-1];
        ext_len[i] = ext_len[i-1];
      end
      ext_base[p] = b_start[31:0];
      ext_len[p] = b_size[31:0];
      ext_count++;
    end
    return ST_OK;
  endfunction

  // send one item; returns the predicted result once the item is taken
  task automatic send_item(input logic fn, input logic [31:0] req, input logic [31:0] off,
                           output out_t res);
    if (!no_gaps && $urandom_range(0, 99) < 35) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= '{func: fn, req_bytes: req, payload_offset_in: off};
    do @(posedge clk); while (busy);
    // item taken at this edge
    if (fn == FUNC_ALLOC) begin
      res = predict_alloc(req);
      if (res.status == ST_OK) begin
        live_off.push_back(res.payload_offset);
        live_req.push_back(req);
      end
    end else begin
      res.status = predict_free(req, off);
      res.payload_offset = '0;
      if (res.status == ST_OK) begin
        foreach (live_off[i]) begin
          if (live_off[i] == off && live_req[i] == req) begin
            live_off.delete(i);
            live_req.delete(i);
            break;
          end
        end
      end
    end
    owed_results.push_back(res);
  endtask

  task automatic do_alloc(input logic [31:0] req);
    out_t r;
    send_item(FUNC_ALLOC, req, $urandom, r);
  endtask

  task automatic do_free(input logic [31:0] req, input logic [31:0] off);
    out_t r;
    send_item(FUNC_FREE, req, off, r);
  endtask

  // give back a random live block
  task automatic free_live();
    int k;
    if (live_off.size() == 0) return;
    k = $urandom_range(0, live_off.size() - 1);
    do_free(live_req[k], live_off[k]);
  endtask

  // lower start, wait until every owed result has come, then let the block drain
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write while idle; a write to either register rebuilds the list, so live blocks are forgotten
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_RESERVED) begin
      pr_reserved = 64'(data[15:0]);
      rebuild_list();
      live_off.delete();
      live_req.delete();
    end else if (idx == CFG_REGION) begin
      pr_region = 64'(data);
      rebuild_list();
      live_off.delete();
      live_req.delete();
    end
    repeat (3) @(posedge clk);
  endtask

  // result checker: one strobe, compared with the oldest owed result
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (owed_results.size() == 0) begin
        $error("unexpected result: status %0d payload_offset %0h",
               out_item.status, out_item.payload_offset);
        errors++;
      end else begin
        out_t w;
        w = owed_results.pop_front();
        if (out_item.status !== w.status) begin
          $error("status: expected %0d actual %0d", w.status, out_item.status);
          errors++;
        end
        if (out_item.payload_offset !== w.payload_offset) begin
          $error("payload_offset: expected %0h actual %0h",
                 w.payload_offset, out_item.payload_offset);
          errors++;
        end
      end
    end
  end

  // sizes, zero requests, bad offsets, a huge request
  task automatic test_edge_cases();
    do_alloc(32'd0);
    do_free(32'd0, 32'd5000);
    do_alloc(32'hFFFF_FFFF);
    do_alloc(32'd1);
    do_free(32'd16, 32'd7);
    do_free(32'd16, 32'd4000);
    do_free(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // overlaps a free extent
    do_free(32'd64, 32'd30000);
    // free of the live block, then a second free whose size and offset come from the now empty live list
    do_free(live_req[0], live_off[0]);
    do_free(live_req[0], live_off[0]);
  endtask

  // exact fit empties the list, then merges on both sides
  task automatic test_fit_and_merge();
    logic [31:0] a, b, c;
    write_reg(CFG_RESERVED, 32'd4096);
    do_alloc(32'd61432);
    do_alloc(32'd1);
    do_free(32'd61432, 32'd4104);
    do_alloc(32'd100);
    do_alloc(32'd200);
    do_alloc(32'd300);
    a = live_off[0];
    b = live_off[1];
    c = live_off[2];
    do_free(32'd100, a);
    do_free(32'd300, c);
    do_free(32'd200, b);
  endtask

  // fragment the list until a free has no slot for a new extent
  task automatic test_list_full();
    write_reg(CFG_REGION, 32'd65536);
    for (int i = 0; i < 132; i++) do_alloc(32'd8);
    for (int i = 0; i < 132; i += 2) do_free(32'd8, 32'd4096 + 16 * i + HEADER_BYTES);
    settle();
  endtask

  // register extremes, including an empty list and an unknown index
  task automatic test_config_extremes();
    write_reg(CFG_RESERVED, 32'hFFFF_0000);
    do_alloc(32'd1);
    write_reg(CFG_REGION, 32'd1);
    do_alloc(32'd1);
    do_free(32'd1, 32'd8);
    write_reg(CFG_RESERVED, 32'hFFFF_FFFF);
    write_reg(CFG_REGION, 32'hFFFF_FFFF);
    do_alloc(32'hFFFF_0000);
    do_alloc(32'hFFFF_FFFF);
    write_reg(CFG_UNUSED, 32'hA5A5_A5A5);
    do_alloc(32'd4);
    write_reg(CFG_RESERVED, 32'd65535);
    write_reg(CFG_REGION, 32'd65535);
    do_alloc(32'd1);
  endtask

  // mostly well-formed alloc/free traffic, with some noise
  task automatic random_phase(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      no_gaps = (i >= n / 4 && i < n / 4 + 60);
      // once the sender waits for every result before going on
      if (i == n / 2) settle();
      r = $urandom_range(0, 99);
      if (r < 45) begin
        if ($urandom_range(0, 19) == 0) do_alloc($urandom);
        else do_alloc($urandom_range(1, 300));
      end else if (r < 85 && live_off.size() != 0) begin
        free_live();
      end else if (r < 92 && live_off.size() != 0) begin
        // overlapping or partial free near a live block
        do_free($urandom_range(1, 64), live_off[0] + $urandom_range(0, 32) - 16);
      end else begin
        do_free($urandom, $urandom);
      end
    end
    no_gaps = 0;
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_item <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    pr_reserved = 64'(RST_RESERVED);
    pr_region = 64'(RST_REGION);
    rebuild_list();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_edge_cases();
    test_fit_and_merge();
    test_list_full();
    test_config_extremes();
    write_reg(CFG_RESERVED, 32'd1024);
    write_reg(CFG_REGION, 32'd40000);
    random_phase(140);
    write_reg(CFG_RESERVED, 32'd0);
    write_reg(CFG_REGION, 32'h0001_0000);
    random_phase(140);
    settle();
    if (errors == 0) begin
      $display("first_fit_free_list_allocator_tb: PASS");
    end else begin
      $display("first_fit_free_list_allocator_tb: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("first_fit_free_list_allocator_tb: FAIL");
    $finish;
  end

endmodule
`default_nettype wire
